// ----- src/e2r_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared widths, constants, types and fixed-point helpers for the
// Euler angle to rotation matrix block.
// ----------------------------------------------------------------------------
package e2r_pkg;

   localparam int ANGLE_W = 16;
   localparam int ENTRY_W = 16;
   localparam int ITERS   = 30;
   localparam int XW      = 33;
   localparam int ZW      = 34;
   localparam int SUM_W   = 34;

   localparam logic signed [XW-1:0] CORDIC_K    = 33'sd652032874;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ENTRY_W-1:0] ONE_Q14 = 16'sd16384;

   typedef struct packed {
      logic signed [XW-1:0] sb;
      logic signed [XW-1:0] cb;
      logic signed [XW-1:0] sa;
      logic signed [XW-1:0] ca;
      logic signed [XW-1:0] sh;
      logic signed [XW-1:0] ch;
   } trig_type;

   typedef struct packed {
      logic signed [XW-1:0] ch_ca;
      logic signed [XW-1:0] sh_sb;
      logic signed [XW-1:0] chsa_cb;
      logic signed [XW-1:0] chsa_sb;
      logic signed [XW-1:0] sh_cb;
      logic signed [XW-1:0] sa;
      logic signed [XW-1:0] ca_cb;
      logic signed [XW-1:0] ca_sb;
      logic signed [XW-1:0] sh_ca;
      logic signed [XW-1:0] shsa_cb;
      logic signed [XW-1:0] ch_sb;
      logic signed [XW-1:0] shsa_sb;
      logic signed [XW-1:0] ch_cb;
   } term_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] r;
      case (idx)
         0: r = 34'sh03243F6A8;
         1: r = 34'sh01DAC6705;
         2: r = 34'sh00FADBAFC;
         3: r = 34'sh007F56EA6;
         4: r = 34'sh003FEAB76;
         5: r = 34'sh001FFD55B;
         6: r = 34'sh000FFFAAA;
         7: r = 34'sh0007FFF55;
         8: r = 34'sh0003FFFEA;
         9: r = 34'sh0001FFFFD;
         10: r = 34'sh0000FFFFF;
         11: r = 34'sh00007FFFF;
         12: r = 34'sh00003FFFF;
         13: r = 34'sh00001FFFF;
         14: r = 34'sh00000FFFF;
         15: r = 34'sh000007FFF;
         16: r = 34'sh000003FFF;
         17: r = 34'sh000001FFF;
         18: r = 34'sh000000FFF;
         19: r = 34'sh0000007FF;
         20: r = 34'sh0000003FF;
         21: r = 34'sh0000001FF;
         22: r = 34'sh0000000FF;
         23: r = 34'sh00000007F;
         24: r = 34'sh00000003F;
         25: r = 34'sh00000001F;
         26: r = 34'sh00000000F;
         27: r = 34'sh000000008;
         28: r = 34'sh000000004;
         29: r = 34'sh000000002;
         default: r = '0;
      endcase
      return r;
   endfunction

   // round-to-nearest Q30 product
   function automatic logic signed [XW-1:0] mul_q30(input logic signed [XW-1:0] a,
                                                    input logic signed [XW-1:0] b);
      logic signed [2*XW-1:0] p;
      p = (2*XW)'(a) * (2*XW)'(b);
      p = p + (2*XW)'(64'sd536870912);
      return XW'(p >>> 30);
   endfunction

   function automatic logic signed [ENTRY_W-1:0] to_q14(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W:0] t;
      logic signed [SUM_W-16:0] r;
      logic signed [ENTRY_W-1:0] q;
      t = (SUM_W+1)'(v) + (SUM_W+1)'(64'sd32768);
      r = (SUM_W-15)'(t >>> 16);
      if (r > (SUM_W-15)'(ONE_Q14))
         q = ONE_Q14;
      else if (r < -(SUM_W-15)'(ONE_Q14))
         q = -ONE_Q14;
      else
         q = ENTRY_W'(r);
      return q;
   endfunction

endpackage

// ----- src/e2r_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_sincos
// Three-lane CORDIC pipeline: range reduction, one rotation per stage,
// and a final sign fix giving sine and cosine of each angle in Q30.
// ----------------------------------------------------------------------------
module e2r_sincos (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]   angle_x,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]   angle_y,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]   angle_z,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output e2r_pkg::trig_type                    out_trig
);

   localparam int ITERS = e2r_pkg::ITERS;
   localparam int XW    = e2r_pkg::XW;
   localparam int ZW    = e2r_pkg::ZW;
   localparam int NS    = ITERS + 2;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   logic signed [XW-1:0] x_ff [3][ITERS+1];
   logic signed [XW-1:0] y_ff [3][ITERS+1];
   logic signed [ZW-1:0] z_ff [3][ITERS+1];
   logic                 flip_ff [3][ITERS+1];
   logic signed [XW-1:0] s_ff [3];
   logic signed [XW-1:0] c_ff [3];

   logic signed [e2r_pkg::ANGLE_W-1:0] ang [3];

   assign ang[0] = angle_x;
   assign ang[1] = angle_y;
   assign ang[2] = angle_z;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || !out_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_stall  = !en[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [ZW-1:0] a_in;
      logic signed [ZW-1:0] z0_in;
      logic                 f0_in;

      always_comb begin
         a_in = ZW'(ang[l]) <<< 17;
         if (a_in > e2r_pkg::HALF_PI_Q30) begin
            z0_in = a_in - e2r_pkg::PI_Q30;
            f0_in = 1'b1;
         end else if (a_in < -e2r_pkg::HALF_PI_Q30) begin
            z0_in = a_in + e2r_pkg::PI_Q30;
            f0_in = 1'b1;
         end else begin
            z0_in = a_in;
            f0_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (en[0]) begin
            x_ff[l][0]    <= e2r_pkg::CORDIC_K;
            y_ff[l][0]    <= '0;
            z_ff[l][0]    <= z0_in;
            flip_ff[l][0] <= f0_in;
         end
      end

      for (genvar k = 1; k <= ITERS; k++) begin : g_iter
         logic signed [XW-1:0] xs;
         logic signed [XW-1:0] ys;
         logic                 dpos;

         assign xs   = x_ff[l][k-1] >>> (k - 1);
         assign ys   = y_ff[l][k-1] >>> (k - 1);
         assign dpos = !z_ff[l][k-1][ZW-1];

         always_ff @(posedge clock) begin
            if (en[k]) begin
               x_ff[l][k]    <= dpos ? x_ff[l][k-1] - ys : x_ff[l][k-1] + ys;
               y_ff[l][k]    <= dpos ? y_ff[l][k-1] + xs : y_ff[l][k-1] - xs;
               z_ff[l][k]    <= dpos ? z_ff[l][k-1] - e2r_pkg::atan_q30(k - 1)
                                     : z_ff[l][k-1] + e2r_pkg::atan_q30(k - 1);
               flip_ff[l][k] <= flip_ff[l][k-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[NS-1]) begin
            s_ff[l] <= flip_ff[l][ITERS] ? -y_ff[l][ITERS] : y_ff[l][ITERS];
            c_ff[l] <= flip_ff[l][ITERS] ? -x_ff[l][ITERS] : x_ff[l][ITERS];
         end
      end
   end

   assign out_trig.sb = s_ff[0];
   assign out_trig.cb = c_ff[0];
   assign out_trig.sa = s_ff[1];
   assign out_trig.ca = c_ff[1];
   assign out_trig.sh = s_ff[2];
   assign out_trig.ch = c_ff[2];

endmodule

// ----- src/e2r_products.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_products
// Two multiply stages: pairwise Q30 products, then the triple products.
// ----------------------------------------------------------------------------
module e2r_products (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  e2r_pkg::trig_type    in_trig,
   output logic                 out_valid,
   input  logic                 out_stall,
   output e2r_pkg::term_type    out_term
);

   localparam int XW = e2r_pkg::XW;

   typedef struct packed {
      logic signed [XW-1:0] ch_ca;
      logic signed [XW-1:0] sh_sb;
      logic signed [XW-1:0] ch_sa;
      logic signed [XW-1:0] sh_sa;
      logic signed [XW-1:0] sh_cb;
      logic signed [XW-1:0] sa;
      logic signed [XW-1:0] ca_cb;
      logic signed [XW-1:0] ca_sb;
      logic signed [XW-1:0] sh_ca;
      logic signed [XW-1:0] ch_sb;
      logic signed [XW-1:0] ch_cb;
      logic signed [XW-1:0] sb;
      logic signed [XW-1:0] cb;
   } pair_type;

   logic               v1_ff, v2_ff;
   logic               en1, en2;
   pair_type           p_ff;
   e2r_pkg::term_type  t_ff;

   assign en2       = !v2_ff || !out_stall;
   assign en1       = !v1_ff || en2;
   assign in_stall  = !en1;
   assign out_valid = v2_ff;
   assign out_term  = t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p_ff.ch_ca <= e2r_pkg::mul_q30(in_trig.ch, in_trig.ca);
         p_ff.sh_sb <= e2r_pkg::mul_q30(in_trig.sh, in_trig.sb);
         p_ff.ch_sa <= e2r_pkg::mul_q30(in_trig.ch, in_trig.sa);
         p_ff.sh_sa <= e2r_pkg::mul_q30(in_trig.sh, in_trig.sa);
         p_ff.sh_cb <= e2r_pkg::mul_q30(in_trig.sh, in_trig.cb);
         p_ff.sa    <= in_trig.sa;
         p_ff.ca_cb <= e2r_pkg::mul_q30(in_trig.ca, in_trig.cb);
         p_ff.ca_sb <= e2r_pkg::mul_q30(in_trig.ca, in_trig.sb);
         p_ff.sh_ca <= e2r_pkg::mul_q30(in_trig.sh, in_trig.ca);
         p_ff.ch_sb <= e2r_pkg::mul_q30(in_trig.ch, in_trig.sb);
         p_ff.ch_cb <= e2r_pkg::mul_q30(in_trig.ch, in_trig.cb);
         p_ff.sb    <= in_trig.sb;
         p_ff.cb    <= in_trig.cb;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         t_ff.ch_ca   <= p_ff.ch_ca;
         t_ff.sh_sb   <= p_ff.sh_sb;
         t_ff.chsa_cb <= e2r_pkg::mul_q30(p_ff.ch_sa, p_ff.cb);
         t_ff.chsa_sb <= e2r_pkg::mul_q30(p_ff.ch_sa, p_ff.sb);
         t_ff.sh_cb   <= p_ff.sh_cb;
         t_ff.sa      <= p_ff.sa;
         t_ff.ca_cb   <= p_ff.ca_cb;
         t_ff.ca_sb   <= p_ff.ca_sb;
         t_ff.sh_ca   <= p_ff.sh_ca;
         t_ff.shsa_cb <= e2r_pkg::mul_q30(p_ff.sh_sa, p_ff.cb);
         t_ff.ch_sb   <= p_ff.ch_sb;
         t_ff.shsa_sb <= e2r_pkg::mul_q30(p_ff.sh_sa, p_ff.sb);
         t_ff.ch_cb   <= p_ff.ch_cb;
      end
   end

endmodule

// ----- src/euler_to_rotation_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Heading-attitude-bank Euler angles (Q2.13 radians) to a 3x3 rotation
// matrix in Q1.14, via CORDIC sine/cosine and a pipelined product network.
//
//   channel  direction  ports                        handshake
//   req      in         req_angle_x/y/z              req_valid / req_stall
//   rsp      out        rsp_r00 .. rsp_r22           rsp_valid / rsp_stall
//
// One item per cycle sustained while rsp_stall is low; 32 CORDIC stages
// (reduction, 30 rotations, sign fix), 2 multiply stages, 1 output stage.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up under a stalled output. Synchronous reset empties the
// pipeline; no state carries between items.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]  req_angle_x,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]  req_angle_y,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]  req_angle_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r00,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r01,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r02,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r10,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r11,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r12,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r20,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r21,
   output logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r22
);

   localparam int SW = e2r_pkg::SUM_W;
   localparam int EW = e2r_pkg::ENTRY_W;

   logic               trig_valid, trig_stall;
   e2r_pkg::trig_type  trig;
   logic               term_valid, term_stall;
   e2r_pkg::term_type  term;
   logic               out_en;
   logic               rsp_valid_ff;
   logic signed [EW-1:0] r_ff [9];

   e2r_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .angle_x   (req_angle_x),
      .angle_y   (req_angle_y),
      .angle_z   (req_angle_z),
      .out_valid (trig_valid),
      .out_stall (trig_stall),
      .out_trig  (trig)
   );

   e2r_products u_products (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_stall  (trig_stall),
      .in_trig   (trig),
      .out_valid (term_valid),
      .out_stall (term_stall),
      .out_term  (term)
   );

   assign out_en     = !rsp_valid_ff || !rsp_stall;
   assign term_stall = !out_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= term_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         r_ff[0] <= e2r_pkg::to_q14(SW'(term.ch_ca));
         r_ff[1] <= e2r_pkg::to_q14(SW'(term.sh_sb) - SW'(term.chsa_cb));
         r_ff[2] <= e2r_pkg::to_q14(SW'(term.chsa_sb) + SW'(term.sh_cb));
         r_ff[3] <= e2r_pkg::to_q14(SW'(term.sa));
         r_ff[4] <= e2r_pkg::to_q14(SW'(term.ca_cb));
         r_ff[5] <= e2r_pkg::to_q14(-SW'(term.ca_sb));
         r_ff[6] <= e2r_pkg::to_q14(-SW'(term.sh_ca));
         r_ff[7] <= e2r_pkg::to_q14(SW'(term.shsa_cb) + SW'(term.ch_sb));
         r_ff[8] <= e2r_pkg::to_q14(SW'(term.ch_cb) - SW'(term.shsa_sb));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_r00   = r_ff[0];
   assign rsp_r01   = r_ff[1];
   assign rsp_r02   = r_ff[2];
   assign rsp_r10   = r_ff[3];
   assign rsp_r11   = r_ff[4];
   assign rsp_r12   = r_ff[5];
   assign rsp_r20   = r_ff[6];
   assign rsp_r21   = r_ff[7];
   assign rsp_r22   = r_ff[8];

   a_stall_origin : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall)
      else $error("input stalled without output backpressure");

   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_r01) && $stable(rsp_r22))
      else $error("stalled result lost");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_r10 <= e2r_pkg::ONE_Q14) && (rsp_r10 >= -e2r_pkg::ONE_Q14)
                 && (rsp_r22 <= e2r_pkg::ONE_Q14) && (rsp_r22 >= -e2r_pkg::ONE_Q14))
      else $error("matrix entry beyond unit range");

endmodule

// ----- tb/e2r_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_checker
// Watches both channels of euler_to_rotation_matrix. Each accepted angle
// triple is turned into the expected matrix by a bit-exact CORDIC model.
// Each returned matrix is compared entry by entry with the oldest one.
// ----------------------------------------------------------------------------
module e2r_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]  req_angle_x,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]  req_angle_y,
   input  logic signed [e2r_pkg::ANGLE_W-1:0]  req_angle_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r00,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r01,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r02,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r10,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r11,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r12,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r20,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r21,
   input  logic signed [e2r_pkg::ENTRY_W-1:0]  rsp_r22,
   output int                                  fail_count,
   output int                                  pending
);

   typedef logic [8:0][e2r_pkg::ENTRY_W-1:0] matrix_t;

   localparam longint ROT_GAIN  = 64'sd652032874;
   localparam longint QUARTER   = 64'sd1686629713;
   localparam longint HALF_TURN = 64'sd3373259426;

   localparam longint ARC_STEP [30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

   localparam string ENTRY_NAME [9] = '{"r00", "r01", "r02", "r10", "r11",
                                        "r12", "r20", "r21", "r22"};

   matrix_t expected_matrices [$];

   task automatic sine_cosine(input logic signed [15:0] angle,
                              output longint s, output longint c);
      longint z, x, y, xs, ys;
      bit     flip;
      z    = longint'(angle) * 131072;
      flip = 0;
      x    = ROT_GAIN;
      y    = 0;
      if (z > QUARTER) begin
         z    = z - HALF_TURN;
         flip = 1;
      end else if (z < -QUARTER) begin
         z    = z + HALF_TURN;
         flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ARC_STEP[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ARC_STEP[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   function automatic longint qmul(input longint p, input longint q);
      return (p * q + 64'sd536870912) >>> 30;
   endfunction

   function automatic logic [15:0] entry_q14(input longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > 16384)
         r = 16384;
      if (r < -16384)
         r = -16384;
      return r[15:0];
   endfunction

   task automatic rotation_of(input logic signed [15:0] bank,
                              input logic signed [15:0] attitude,
                              input logic signed [15:0] heading,
                              output matrix_t m);
      longint sb, cb, sa, ca, sh, ch, chsa, shsa;
      sine_cosine(bank, sb, cb);
      sine_cosine(attitude, sa, ca);
      sine_cosine(heading, sh, ch);
      chsa = qmul(ch, sa);
      shsa = qmul(sh, sa);
      m[0] = entry_q14(qmul(ch, ca));
      m[1] = entry_q14(qmul(sh, sb) - qmul(chsa, cb));
      m[2] = entry_q14(qmul(chsa, sb) + qmul(sh, cb));
      m[3] = entry_q14(sa);
      m[4] = entry_q14(qmul(ca, cb));
      m[5] = entry_q14(-qmul(ca, sb));
      m[6] = entry_q14(-qmul(sh, ca));
      m[7] = entry_q14(qmul(shsa, cb) + qmul(ch, sb));
      m[8] = entry_q14(-qmul(shsa, sb) + qmul(ch, cb));
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      matrix_t m, got, want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            rotation_of(req_angle_x, req_angle_y, req_angle_z, m);
            expected_matrices = {expected_matrices, m};
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_r22, rsp_r21, rsp_r20, rsp_r12, rsp_r11, rsp_r10,
                   rsp_r02, rsp_r01, rsp_r00};
            if (expected_matrices.size() == 0) begin
               $error("unexpected item on rsp channel");
               fail_count++;
            end else begin
               want = expected_matrices.pop_front();
               for (int k = 0; k < 9; k++)
                  if (got[k] !== want[k]) begin
                     $error("%s: expected %0d, got %0d", ENTRY_NAME[k],
                            $signed(want[k]), $signed(got[k]));
                     fail_count++;
                  end
            end
         end
         pending = expected_matrices.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for euler_to_rotation_matrix: directed angle corners (zero,
// range ends, quarter and half turn boundaries) then random triples under
// several idling and stalling mixes. Checking is done by e2r_checker.
// ----------------------------------------------------------------------------
module tb;

   localparam int LATENCY = 35;

   logic clock = 0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [e2r_pkg::ANGLE_W-1:0] req_angle_x, req_angle_y, req_angle_z;
   logic signed [e2r_pkg::ENTRY_W-1:0] rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11;
   logic signed [e2r_pkg::ENTRY_W-1:0] rsp_r12, rsp_r20, rsp_r21, rsp_r22;
   int fail_count, pending;
   int idle_pct, stall_pct;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   euler_to_rotation_matrix dut (.*);

   e2r_checker u_checker (.*);

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   function automatic logic [15:0] pick_angle();
      logic [15:0] corner [10] = '{16'h8000, 16'h7FFF, 16'h0000, 16'd12867,
                                   16'd12868, -16'sd12867, -16'sd12868,
                                   16'd25736, -16'sd25736, 16'hFFFF};
      if ($urandom_range(4) == 0)
         return 16'(corner[$urandom_range(9)] + $urandom_range(4) - 2);
      return 16'($urandom());
   endfunction

   task automatic send(input logic [15:0] ax, input logic [15:0] ay,
                       input logic [15:0] az);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid   <= 1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      logic [15:0] corner [9] = '{16'h0000, 16'h8000, 16'h7FFF, 16'd12867,
                                  16'd12868, -16'sd12867, -16'sd12868,
                                  16'd25736, 16'h0001};
      int idle_mix [4]  = '{0, 87, 0, 26};
      int stall_mix [4] = '{0, 0, 87, 26};
      reset       <= 1;
      req_valid   <= 0;
      req_angle_x <= 0;
      req_angle_y <= 0;
      req_angle_z <= 0;
      rsp_stall   <= 0;
      idle_pct    = 0;
      stall_pct   = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int i = 0; i < 9; i++)
         send(corner[i], corner[i], corner[i]);
      for (int i = 0; i < 9; i++)
         send(corner[i], corner[(i + 3) % 9], corner[(i + 6) % 9]);
      send(16'h7FFF, 16'h8000, 16'h7FFF);
      send(16'h8000, 16'h7FFF, 16'h8000);

      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_mix[p];
         stall_pct = stall_mix[p];
         for (int n = 0; n < 238; n++)
            send(pick_angle(), pick_angle(), pick_angle());
      end
      req_valid <= 0;
      stall_pct = 0;

      while (pending != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** euler_to_rotation_matrix: PASSED **");
      else
         $display("** euler_to_rotation_matrix: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("** euler_to_rotation_matrix: FAILED **");
      $finish;
   end

endmodule
